// ===== hdl/tilt_complementary_filter_unit_macros.svh =====
// Assertion macros for the tilt filter RTL.
// Used by files that check their own control logic; no other dependencies.
`ifndef TILT_COMPLEMENTARY_FILTER_UNIT_MACROS_SVH
`define TILT_COMPLEMENTARY_FILTER_UNIT_MACROS_SVH
`ifndef SYNTH
`define TCF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("tcf check failed");
`define TCF_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("tcf reset check failed");
`else
`define TCF_ASSERT(lbl, prop)
`define TCF_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== hdl/tcf_pkg.sv =====
// Shared types, constants and the arctangent table for the tilt filter.
// No dependencies.
`timescale 1ns / 1ps
package tcf_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int SHIFT_W      = 5;
  localparam int VEC_W        = 34;
  localparam int ANG_W        = 26;
  localparam int STATE_W      = 24;

  localparam logic [15:0] ALPHA_RESET   = 16'd61604;
  localparam logic [15:0] GAIN_COMP_Q16 = 16'd39797;
  localparam logic [15:0] DT_MAX_US     = 16'd50000;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 26'sd3294199;
  localparam logic signed [STATE_W:0] STATE_MAX = 25'sd8388607;
  localparam logic signed [STATE_W:0] STATE_MIN = -25'sd8388608;

  // gyro step divides by 10^6 = 2^6 * 15625
  localparam int          DIV_BITS = 21;
  localparam int          DIV_NUM_W = 35;
  localparam logic [DIV_NUM_W-1:0] DIV_DEN = 35'd15625;
  localparam logic [DIV_NUM_W-1:0] DIV_RND = 35'd7812;
  // quotient estimate: (num >> 14) * floor(2^40 / 15625) >> 26, low by at most 2
  localparam int          DIV_HI_LSB   = 14;
  localparam int          DIV_RECIP_SH = 26;
  localparam int          DIV_PROD_W   = 48;
  localparam logic [26:0] DIV_RECIP    = 27'd70368744;
  localparam logic [15:0] DIV_DEN_LO   = 16'd15625;
  localparam logic [15:0] DIV_DEN2_LO  = 16'd31250;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic [23:0]        elapsed_us;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
  } out_word_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } vec_t;

  // atan(2^-i) in Q2.21
  function automatic logic signed [ANG_W-1:0] atan_q21(input logic [SHIFT_W-1:0] i);
    logic signed [ANG_W-1:0] v;
    case (i)
      5'd0:  v = 26'sd1647099;
      5'd1:  v = 26'sd972340;
      5'd2:  v = 26'sd513757;
      5'd3:  v = 26'sd260791;
      5'd4:  v = 26'sd130902;
      5'd5:  v = 26'sd65515;
      5'd6:  v = 26'sd32765;
      5'd7:  v = 26'sd16384;
      5'd8:  v = 26'sd8192;
      5'd9:  v = 26'sd4096;
      5'd10: v = 26'sd2048;
      5'd11: v = 26'sd1024;
      5'd12: v = 26'sd512;
      5'd13: v = 26'sd256;
      5'd14: v = 26'sd128;
      5'd15: v = 26'sd64;
      5'd16: v = 26'sd32;
      5'd17: v = 26'sd16;
      5'd18: v = 26'sd8;
      5'd19: v = 26'sd4;
      5'd20: v = 26'sd2;
      5'd21: v = 26'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/tilt_complementary_filter_unit.sv =====
// Tilt complementary filter top level: sequencer, CORDIC cell chain, gyro dividers, blend.
// Depends on tcf_pkg, tcf_cordic_cell, tcf_gyro_div and the macros header.
//
// Usage:
//   in_valid/in_ready/in_data carry one IMU sample word; out_valid/out_ready/out_data
//   carry the filtered roll and pitch in Q2.13. cfg_wr_en/cfg_wr_data write the gyro
//   weight alpha (Q0.16), which each sample reads at its blend step.
//   One sample is processed at a time: in_ready is high only while the sequencer is
//   idle. The path from accept to out_valid is set by two passes through the 16-cell
//   CORDIC chain (roll, then pitch, which needs the roll magnitude) plus gain, gyro
//   and blend steps. The gyro divides run alongside.
//   A finished result sits in the output register; the next sample is accepted while
//   it waits. If the receiver still stalls when the next result is done, the
//   sequencer holds that result and the stored angles until the register frees.
//   Reset (rst_n low, synchronous) clears the angle state to zero, sets alpha to
//   0.94 and empties the output register.
`timescale 1ns / 1ps
`include "tilt_complementary_filter_unit_macros.svh"
module tilt_complementary_filter_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcf_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tcf_pkg::out_word_t  out_data,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data
);

  localparam int N = tcf_pkg::CORDIC_STEPS;
  localparam int VW = tcf_pkg::VEC_W;
  localparam int AW = tcf_pkg::ANG_W;
  localparam int SW = tcf_pkg::STATE_W;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_ROLL, S_GAIN, S_PLOAD, S_PITCH, S_GYRO, S_MULT, S_DONE
  } state_t;

  state_t state_r;

  logic [15:0] blend_weight_r;

  // sample and intermediates
  logic signed [15:0] ax_r, ay_r, az_r;
  logic signed [31:0] prod_roll_r, prod_pitch_r;
  logic signed [AW-1:0] roll_acc_r, pitch_acc_r;
  logic [30:0] mag_r;
  logic [30:0] mag_g_r;
  logic signed [SW-1:0] roll_g_r, pitch_g_r;
  logic signed [SW-1:0] last_roll_r, last_pitch_r;
  logic signed [40:0] mg_roll_r, mg_pitch_r;
  logic signed [43:0] ma_roll_r, ma_pitch_r;
  logic out_valid_r;
  tcf_pkg::out_word_t out_data_r;

  // chain
  tcf_pkg::vec_t chain_vec [0:N];
  logic [N:0]    chain_vld;
  tcf_pkg::vec_t roll_in, pitch_in;

  function automatic tcf_pkg::vec_t prep(input logic signed [VW-1:0] y,
                                         input logic signed [VW-1:0] x);
    tcf_pkg::vec_t v;
    v.x = x;
    v.y = y;
    v.z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        v.x = y;
        v.y = -x;
        v.z = tcf_pkg::ANG_HALF_PI;
      end else begin
        v.x = -y;
        v.y = x;
        v.z = -tcf_pkg::ANG_HALF_PI;
      end
    end
    return v;
  endfunction

  function automatic logic signed [SW-1:0] sat_st(input logic signed [SW:0] v);
    logic signed [SW-1:0] r;
    if (v > tcf_pkg::STATE_MAX) begin
      r = tcf_pkg::STATE_MAX[SW-1:0];
    end else if (v < tcf_pkg::STATE_MIN) begin
      r = tcf_pkg::STATE_MIN[SW-1:0];
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  always_comb begin
    roll_in  = prep({{4{ay_r[15]}}, ay_r, 14'b0}, {{4{az_r[15]}}, az_r, 14'b0});
    pitch_in = prep(-{{4{ax_r[15]}}, ax_r, 14'b0}, {3'b0, mag_g_r});
  end

  assign chain_vec[0] = (state_r == S_PLOAD) ? pitch_in : roll_in;
  assign chain_vld[0] = (state_r == S_LOAD) || (state_r == S_PLOAD);

  for (genvar g = 0; g < N; g++) begin : g_cell
    tcf_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_vld    (chain_vld[g]),
      .in_vec    (chain_vec[g]),
      .shift_amt (tcf_pkg::SHIFT_W'(g)),
      .out_vld   (chain_vld[g+1]),
      .out_vec   (chain_vec[g+1])
    );
  end

  tcf_pkg::vec_t end_vec;
  assign end_vec = chain_vec[N];

  // gyro dividers: |rate*dt|*16 + 7812, over 15625
  logic div_start;
  logic [tcf_pkg::DIV_NUM_W-1:0] num_roll, num_pitch;
  logic [tcf_pkg::DIV_BITS-1:0]  q_roll, q_pitch;
  logic done_roll, done_pitch;
  logic [31:0] abs_roll, abs_pitch;

  assign div_start = (state_r == S_LOAD);
  assign abs_roll  = prod_roll_r[31]  ? 32'(-prod_roll_r)  : 32'(prod_roll_r);
  assign abs_pitch = prod_pitch_r[31] ? 32'(-prod_pitch_r) : 32'(prod_pitch_r);
  assign num_roll  = {abs_roll[30:0], 4'b0} + tcf_pkg::DIV_RND;
  assign num_pitch = {abs_pitch[30:0], 4'b0} + tcf_pkg::DIV_RND;

  tcf_gyro_div u_div_roll (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(num_roll),
    .quo(q_roll), .done(done_roll)
  );
  tcf_gyro_div u_div_pitch (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(num_pitch),
    .quo(q_pitch), .done(done_pitch)
  );

  // combinational helpers
  logic [15:0] dt_clamp;
  logic signed [16:0] dt_s;
  logic signed [SW:0] step_roll, step_pitch;
  logic [46:0] gain_prod;
  logic signed [16:0] w_g;
  logic signed [17:0] w_a;
  logic signed [44:0] sum_roll, sum_pitch;
  logic signed [SW-1:0] blend_roll, blend_pitch;
  logic out_free;

  always_comb begin
    dt_clamp = (in_data.elapsed_us > 24'(tcf_pkg::DT_MAX_US)) ? tcf_pkg::DT_MAX_US
                                                              : in_data.elapsed_us[15:0];
    dt_s = $signed({1'b0, dt_clamp});
    step_roll  = prod_roll_r[31]  ? -$signed({4'b0, q_roll})  : $signed({4'b0, q_roll});
    step_pitch = prod_pitch_r[31] ? -$signed({4'b0, q_pitch}) : $signed({4'b0, q_pitch});
    gain_prod = 47'(mag_r) * 47'(tcf_pkg::GAIN_COMP_Q16);
    w_g = $signed({1'b0, blend_weight_r});
    w_a = $signed(18'h10000 - {2'b0, blend_weight_r});
    sum_roll  = 45'(mg_roll_r) + 45'(ma_roll_r) + 45'sd32768;
    sum_pitch = 45'(mg_pitch_r) + 45'(ma_pitch_r) + 45'sd32768;
    blend_roll  = sat_st(25'(sum_roll >>> 16));
    blend_pitch = sat_st(25'(sum_pitch >>> 16));
    out_free = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_weight_r <= tcf_pkg::ALPHA_RESET;
    end else if (cfg_wr_en) begin
      blend_weight_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      last_roll_r  <= '0;
      last_pitch_r <= '0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_LOAD;
          end
        end
        S_LOAD:  state_r <= S_ROLL;
        S_ROLL: begin
          if (chain_vld[N]) begin
            state_r <= S_GAIN;
          end
        end
        S_GAIN:  state_r <= S_PLOAD;
        S_PLOAD: state_r <= S_PITCH;
        S_PITCH: begin
          if (chain_vld[N]) begin
            state_r <= S_GYRO;
          end
        end
        S_GYRO: begin
          if (done_roll && done_pitch) begin
            state_r <= S_MULT;
          end
        end
        S_MULT:  state_r <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            last_roll_r  <= blend_roll;
            last_pitch_r <= blend_pitch;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
    // payload
    if (state_r == S_IDLE && in_valid) begin
      ax_r <= in_data.accel_x;
      ay_r <= in_data.accel_y;
      az_r <= in_data.accel_z;
      prod_roll_r  <= 32'(in_data.gyro_x * dt_s);
      prod_pitch_r <= 32'(in_data.gyro_y * dt_s);
    end
    if (state_r == S_ROLL && chain_vld[N]) begin
      // zero vector gives angle and magnitude 0
      if (ay_r == 0 && az_r == 0) begin
        roll_acc_r <= '0;
        mag_r      <= '0;
      end else begin
        roll_acc_r <= end_vec.z;
        mag_r      <= end_vec.x[VW-1] ? '0 : end_vec.x[30:0];
      end
    end
    if (state_r == S_GAIN) begin
      mag_g_r <= gain_prod[46:16];
    end
    if (state_r == S_PITCH && chain_vld[N]) begin
      pitch_acc_r <= (ax_r == 0 && mag_g_r == 0) ? '0 : end_vec.z;
    end
    if (state_r == S_GYRO) begin
      roll_g_r  <= sat_st(25'(last_roll_r) + step_roll);
      pitch_g_r <= sat_st(25'(last_pitch_r) + step_pitch);
    end
    if (state_r == S_MULT) begin
      mg_roll_r  <= w_g * roll_g_r;
      mg_pitch_r <= w_g * pitch_g_r;
      ma_roll_r  <= w_a * roll_acc_r;
      ma_pitch_r <= w_a * pitch_acc_r;
    end
    if (state_r == S_DONE && out_free) begin
      out_data_r.roll_angle  <= blend_roll[SW-1:8];
      out_data_r.pitch_angle <= blend_pitch[SW-1:8];
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // only one vector travels the chain at a time
  `TCF_ASSERT(a_one_vec, $countones(chain_vld) <= 1)
  // chain output arrives only while the sequencer waits for it
  `TCF_ASSERT(a_end_wait, chain_vld[N] |-> (state_r == S_ROLL || state_r == S_PITCH))
  // an accepted word starts the sequence
  `TCF_ASSERT(a_accept, (in_valid && in_ready) |=> state_r == S_LOAD)
  // a finished word is posted to the output register
  `TCF_ASSERT(a_post, (state_r == S_DONE && out_free) |=> (out_valid_r && in_ready))
  `TCF_ASSERT_RST(a_rst, !rst_n |=> (!out_valid_r && state_r == S_IDLE))

endmodule

// ===== hdl/tcf_cordic_cell.sv =====
// One CORDIC vectoring micro-rotation with a registered output.
// Depends on tcf_pkg.
`timescale 1ns / 1ps
module tcf_cordic_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  tcf_pkg::vec_t                 in_vec,
  input  logic [tcf_pkg::SHIFT_W-1:0]   shift_amt,
  output logic                          out_vld,
  output tcf_pkg::vec_t                 out_vec
);

  logic          vld_r;
  tcf_pkg::vec_t vec_r;
  tcf_pkg::vec_t vec_nxt;
  logic signed [tcf_pkg::VEC_W-1:0] dx;
  logic signed [tcf_pkg::VEC_W-1:0] dy;

  always_comb begin
    dx = in_vec.y >>> shift_amt;
    dy = in_vec.x >>> shift_amt;
    if (in_vec.y >= 0) begin
      vec_nxt.x = in_vec.x + dx;
      vec_nxt.y = in_vec.y - dy;
      vec_nxt.z = in_vec.z + tcf_pkg::atan_q21(shift_amt);
    end else begin
      vec_nxt.x = in_vec.x - dx;
      vec_nxt.y = in_vec.y + dy;
      vec_nxt.z = in_vec.z - tcf_pkg::atan_q21(shift_amt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
    vec_r <= vec_nxt;
  end

  assign out_vld = vld_r;
  assign out_vec = vec_r;

endmodule

// ===== hdl/tcf_gyro_div.sv =====
// Divide by the constant 15625 for the gyro step: reciprocal multiply plus fix-up,
// registered through product, estimate, remainder and quotient. Depends on tcf_pkg.
`timescale 1ns / 1ps
module tcf_gyro_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [tcf_pkg::DIV_NUM_W-1:0]   num,
  output logic [tcf_pkg::DIV_BITS-1:0]    quo,
  output logic                            done
);

  logic [tcf_pkg::DIV_NUM_W-1:0]  num_r;
  logic [tcf_pkg::DIV_PROD_W-1:0] prod_r;
  logic [tcf_pkg::DIV_BITS-1:0]   est_r;
  logic [tcf_pkg::DIV_NUM_W-1:0]  back_r;
  logic [15:0]                    rem_r;
  logic [tcf_pkg::DIV_BITS-1:0]   quo_r;
  logic [3:0]                     vld_r;
  logic                           done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      done_r <= 1'b0;
    end else begin
      vld_r <= {vld_r[2:0], start};
      if (start) begin
        done_r <= 1'b0;
      end else if (vld_r[3]) begin
        done_r <= 1'b1;
      end
    end
    // num_r holds until the next start
    if (start) begin
      num_r <= num;
    end
    if (vld_r[0]) begin
      prod_r <= tcf_pkg::DIV_PROD_W'(num_r[tcf_pkg::DIV_NUM_W-1:tcf_pkg::DIV_HI_LSB]) *
                tcf_pkg::DIV_PROD_W'(tcf_pkg::DIV_RECIP);
    end
    if (vld_r[1]) begin
      est_r  <= prod_r[tcf_pkg::DIV_RECIP_SH+tcf_pkg::DIV_BITS-1:tcf_pkg::DIV_RECIP_SH];
      back_r <= tcf_pkg::DIV_NUM_W'(
                  prod_r[tcf_pkg::DIV_RECIP_SH+tcf_pkg::DIV_BITS-1:tcf_pkg::DIV_RECIP_SH]) *
                tcf_pkg::DIV_DEN;
    end
    if (vld_r[2]) begin
      rem_r <= 16'(num_r - back_r);
    end
    if (vld_r[3]) begin
      if (rem_r >= tcf_pkg::DIV_DEN2_LO) begin
        quo_r <= est_r + tcf_pkg::DIV_BITS'(2);
      end else if (rem_r >= tcf_pkg::DIV_DEN_LO) begin
        quo_r <= est_r + tcf_pkg::DIV_BITS'(1);
      end else begin
        quo_r <= est_r;
      end
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for tilt_complementary_filter_unit: drives IMU sample words, predicts roll/pitch.
// Depends on tcf_pkg and the RTL top level.
`timescale 1ns / 1ps
class tilt_scoreboard;
  tcf_pkg::out_word_t angle_q[$];
  int errors;
  logic [15:0] alpha;
  logic signed [23:0] roll_st, pitch_st;

  function void clear_state();
    alpha = tcf_pkg::ALPHA_RESET;
    roll_st = '0;
    pitch_st = '0;
  endfunction

  function longint fshr(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function longint sat24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function longint atan_q21(int i);
    longint tab[22] = '{1647099, 972340, 513757, 260791, 130902, 65515, 32765, 16384,
                        8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
    return (i < 22) ? tab[i] : 0;
  endfunction

  function longint vec_angle(longint y, longint x, output longint mag);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 3294199;
      end else begin
        x = -y; y = t; z = -3294199;
      end
    end
    for (int i = 0; i < 16; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_q21(i);
      end else begin
        x -= dx; y += dy; z -= atan_q21(i);
      end
    end
    mag = (x < 0) ? 0 : x;
    return z;
  endfunction

  function longint gyro_delta(longint rate, longint dt);
    longint p;
    p = rate * dt * 1024;
    if (p >= 0) return (p + 500000) / 1000000;
    return -((-p + 500000) / 1000000);
  endfunction

  function longint mix(longint g, longint a);
    longint w;
    w = alpha;
    return sat24(fshr(w * g + (65536 - w) * a + 32768, 16));
  endfunction

  function void note_sample(tcf_pkg::in_word_t s);
    longint dt, mag, mag2, ra, pa, rg, pg, r, p;
    tcf_pkg::out_word_t e;
    dt = s.elapsed_us;
    if (dt > 50000) dt = 50000;
    ra = vec_angle(longint'(s.accel_y) * 16384, longint'(s.accel_z) * 16384, mag);
    mag = (mag * 39797) >>> 16;
    pa = vec_angle(-longint'(s.accel_x) * 16384, mag, mag2);
    rg = sat24(longint'(roll_st) + gyro_delta(s.gyro_x, dt));
    pg = sat24(longint'(pitch_st) + gyro_delta(s.gyro_y, dt));
    r = mix(rg, ra);
    p = mix(pg, pa);
    roll_st = 24'(r);
    pitch_st = 24'(p);
    e.roll_angle = 16'(fshr(r, 8));
    e.pitch_angle = 16'(fshr(p, 8));
    angle_q.push_back(e);
  endfunction

  function void check_angles(tcf_pkg::out_word_t got);
    tcf_pkg::out_word_t e;
    if (angle_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected word roll=%0d pitch=%0d",
                                 got.roll_angle, got.pitch_angle);
      return;
    end
    e = angle_q.pop_front();
    if (got !== e) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp roll=%0d pitch=%0d got roll=%0d pitch=%0d",
                  e.roll_angle, e.pitch_angle, got.roll_angle, got.pitch_angle);
    end
  endfunction
endclass

module tb;
  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, out_ready = 1'b0, cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic in_ready, out_valid;
  tcf_pkg::in_word_t in_data = '0;
  tcf_pkg::out_word_t out_data;
  int send_idle = 18, recv_idle = 64;
  int quiet_cycles = 0;
  tilt_scoreboard sb;

  always #2 clk = ~clk;

  tilt_complementary_filter_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // receiver side and checking
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_angles(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      out_ready <= ($urandom_range(99) >= recv_idle);
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // valid stays high after an accept until the next word or an idle cycle
  task automatic send_sample(tcf_pkg::in_word_t s);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data <= s;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(s);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.angle_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_alpha(logic [15:0] w);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.alpha = w;
  endtask

  function automatic tcf_pkg::in_word_t rand_sample();
    tcf_pkg::in_word_t s;
    s.accel_x = 16'($urandom);
    s.accel_y = 16'($urandom);
    s.accel_z = 16'($urandom);
    s.gyro_x = 16'($urandom);
    s.gyro_y = 16'($urandom);
    s.elapsed_us = 24'($urandom);
    case ($urandom_range(3))
      0: s.elapsed_us = 24'($urandom_range(2000));
      1: s.elapsed_us = 24'($urandom_range(60000));
      default: ;
    endcase
    if ($urandom_range(3) == 0) begin
      s.accel_x = 16'($urandom_range(0, 4000) - 2000);
      s.accel_y = 16'($urandom_range(0, 4000) - 2000);
      s.accel_z = 16'd16384;
    end
    return s;
  endfunction

  task automatic run_directed();
    int v[5] = '{-32768, 32767, 0, -1, 1};
    tcf_pkg::in_word_t s;
    foreach (v[i]) begin
      s = '{16'(v[i]), 16'(v[(i+1)%5]), 16'(v[(i+2)%5]), 16'(v[(i+3)%5]),
            16'(v[(i+4)%5]), 24'd1000};
      send_sample(s);
    end
    send_sample('{16'sd0, 16'sd0, 16'sd0, 16'sd100, -16'sd100, 24'd500});    // zero vector
    send_sample('{16'sd100, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 24'd500});  // atan2(0, -)
    send_sample('{16'sd0, 16'sd500, -16'sd9000, 16'sd0, 16'sd0, 24'd50000});
    send_sample('{16'sd0, -16'sd500, -16'sd9000, 16'sd0, 16'sd0, 24'd50001});
    send_sample('{16'sd0, 16'sd0, 16'sd16384, 16'sd32767, -16'sd32768, 24'hFFFFFF});
    for (int k = 0; k < 8; k++)   // drive gyro state toward saturation
      send_sample('{16'sd0, 16'sd0, 16'sd16384, 16'sd32767, -16'sd32768, 24'hFFFFFF});
    send_sample('{-16'sd32768, 16'sd32767, 16'sd32767, 16'sd0, 16'sd0, 24'd0});
  endtask

  initial begin
    sb = new();
    sb.clear_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    drain();
    set_alpha(16'd65535);
    run_directed();
    drain();
    set_alpha(16'd0);
    run_directed();
    for (int n = 0; n < 1100; n++) begin
      if (n == 370) begin
        send_idle = 64; recv_idle = 18;
      end
      if (n == 740) begin
        send_idle = 0; recv_idle = 0;
      end
      if (n % 275 == 0) begin
        drain();
        set_alpha(n == 550 ? 16'd61604 : 16'($urandom));
      end
      send_sample(rand_sample());
    end
    drain();
    if (sb.errors == 0 && sb.angle_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

// ===== tilt_complementary_filter_unit.f =====
+incdir+hdl
hdl/tcf_pkg.sv
hdl/tcf_cordic_cell.sv
hdl/tcf_gyro_div.sv
hdl/tilt_complementary_filter_unit.sv
tb/sv/tb.sv
